>>> sv/cre_pkg.sv
`default_nettype none
package cre_pkg;

	// Table size and field widths.
	localparam int MaxPoints = 16;
	localparam int CntW      = $clog2(MaxPoints + 1);
	localparam int IdxW      = $clog2(MaxPoints);
	localparam int TimeW     = 17;
	localparam int LevW      = 16;
	localparam int PtsW      = 5;
	localparam int FracW     = 17;
	localparam int SW        = 42;
	localparam int AccW      = 63;
	localparam int DivSteps  = FracW;
	localparam int MulSteps  = 5;

	typedef enum logic [1:0] {
		MODE_QUERY  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_ONE,
		IDX_LAST,
		IDX_INC,
		IDX_DEC,
		IDX_ADD2,
		IDX_ADD3
	} idx_op_t;

	typedef enum logic [2:0] {
		RES_ONE,
		RES_RD,
		RES_P1,
		RES_P2,
		RES_CUBIC
	} res_sel_t;

	typedef enum logic [1:0] {
		SUM_CD,
		SUM_B,
		SUM_A
	} sum_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     do_insert;
		logic     do_clear;
		logic     load_query;
		idx_op_t  idx_op;
		logic     cap_hi;
		logic     cap_lo;
		logic     cap_p0;
		logic     p0_dup;
		logic     cap_p3;
		logic     res_load;
		res_sel_t res_sel;
		logic     div_init;
		logic     div_step;
		logic     mul_step;
		logic     mul_first;
		logic [2:0] mul_nib;
		sum_sel_t sum_sel;
		logic     s_load;
		logic     out_load;
		logic     out_query;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_zero;
		logic n_one;
		logic tq_le_rd;
		logic tq_ge_rd;
		logic rd_t_eq_t1;
		logic rd_t_eq_t0;
		logic rd_l_eq_p2;
		logic idx_zero;
	} status_t;

endpackage
`default_nettype wire

>>> sv/cre_item_if.sv
`default_nettype none
interface cre_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [16:0] time_pos;
	logic signed [15:0] level;

	modport source(output valid, output mode, output time_pos, output level, input ready);
	modport sink(input valid, input mode, input time_pos, input level, output ready);
endinterface
`default_nettype wire

>>> sv/cre_result_if.sv
`default_nettype none
interface cre_result_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] amplitude;
	logic        table_full;
	logic [4:0]  stored_points;

	modport source(output valid, output amplitude, output table_full, output stored_points,
		input ready);
	modport sink(input valid, input amplitude, input table_full, input stored_points,
		output ready);
endinterface
`default_nettype wire

>>> sv/cre_dp.sv
`default_nettype none
module cre_dp
	import cre_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output status_t                     status,
	input  wire logic [TimeW-1:0]       in_time,
	input  wire logic signed [LevW-1:0] in_level,
	output logic signed [LevW-1:0]      amplitude,
	output logic                        table_full,
	output logic [PtsW-1:0]             stored_points
);

	logic [TimeW-1:0]       bp_time_q  [MaxPoints];
	logic signed [LevW-1:0] bp_level_q [MaxPoints];
	logic [CntW-1:0]        count_q;
	logic [CntW-1:0]        count_next;
	logic                   full;
	logic                   ins_ok;

	logic [IdxW-1:0]        idx_q;
	logic [TimeW-1:0]       rd_time;
	logic signed [LevW-1:0] rd_level;

	logic [TimeW-1:0]       tq_q, t0_q, t1_q;
	logic signed [LevW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic                   p3_ok_q;
	logic signed [LevW-1:0] res_q;

	logic [TimeW:0]         rem_q;
	logic [TimeW-1:0]       den_q;
	logic [FracW-1:0]       quo_q;
	logic                   div_ge;
	logic [TimeW:0]         div_diff;

	logic signed [SW-1:0]   e0, e1, e2, e3;
	logic signed [SW-1:0]   coef_a, coef_b, coef_c, coef_d;
	logic signed [SW-1:0]   s_q;
	logic signed [SW-1:0]   mop;
	logic [19:0]            f20;
	logic [4:0]             nib_sh;
	logic [3:0]             nib_val;
	logic signed [SW+4:0]   term;
	logic signed [AccW-1:0] acc_q;
	logic signed [AccW-1:0] acc_rnd;
	logic signed [SW-1:0]   s_rnd;
	logic signed [SW-1:0]   amp_wide;
	logic signed [LevW-1:0] amp_sat;

	// Table occupancy.
	assign full   = (count_q == CntW'(MaxPoints));
	assign ins_ok = cmd.do_insert && !full;

	always_comb begin
		count_next = count_q;
		if (cmd.do_clear) begin
			count_next = '0;
		end else if (ins_ok) begin
			count_next = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Sorted insert: entries above the new time all move up one place at once.
	for (genvar k = 0; k < MaxPoints; k++) begin : g_entry
		logic new_here;
		logic shift_here;
		assign new_here = (CntW'(k) == count_q) ||
			((CntW'(k) < count_q) && (bp_time_q[k] > in_time));
		if (k == 0) begin : g_first
			assign shift_here = 1'b0;
		end else begin : g_rest
			assign shift_here = (CntW'(k - 1) < count_q) && (bp_time_q[k-1] > in_time);
		end
		always_ff @(posedge clk) begin
			if (ins_ok) begin
				if (shift_here) begin
					bp_time_q[k]  <= bp_time_q[(k == 0) ? 0 : k - 1];
					bp_level_q[k] <= bp_level_q[(k == 0) ? 0 : k - 1];
				end else if (new_here) begin
					bp_time_q[k]  <= in_time;
					bp_level_q[k] <= in_level;
				end
			end
		end
	end

	// Single read port at the walk index.
	assign rd_time  = bp_time_q[idx_q];
	assign rd_level = bp_level_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			unique case (cmd.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_ZERO: idx_q <= '0;
				IDX_ONE:  idx_q <= IdxW'(1);
				IDX_LAST: idx_q <= IdxW'(count_q - 1'b1);
				IDX_INC:  idx_q <= idx_q + IdxW'(1);
				IDX_DEC:  idx_q <= idx_q - IdxW'(1);
				IDX_ADD2: idx_q <= idx_q + IdxW'(2);
				IDX_ADD3: idx_q <= idx_q + IdxW'(3);
				default:  idx_q <= idx_q;
			endcase
		end
	end

	// Segment endpoints and neighbor levels.
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			tq_q <= in_time;
		end
		if (cmd.cap_hi) begin
			t1_q <= rd_time;
			p2_q <= rd_level;
		end
		if (cmd.cap_lo) begin
			t0_q    <= rd_time;
			p1_q    <= rd_level;
			p3_ok_q <= ((CntW + 1)'(idx_q) + (CntW + 1)'(2)) < (CntW + 1)'(count_q);
		end
		if (cmd.cap_p0) begin
			p0_q <= rd_level;
		end else if (cmd.p0_dup) begin
			// The first segment has no left neighbor, so it reuses its own start level.
			p0_q <= rd_level;
		end
		if (cmd.cap_p3) begin
			p3_q <= p3_ok_q ? rd_level : p2_q;
		end
	end

	assign status.n_zero     = (count_q == '0);
	assign status.n_one      = (count_q == CntW'(1));
	assign status.tq_le_rd   = (tq_q <= rd_time);
	assign status.tq_ge_rd   = (tq_q >= rd_time);
	assign status.rd_t_eq_t1 = (rd_time == t1_q);
	assign status.rd_t_eq_t0 = (rd_time == t0_q);
	assign status.rd_l_eq_p2 = (rd_level == p2_q);
	assign status.idx_zero   = (idx_q == '0);

	// Restoring divider: one fraction bit per cycle.
	assign div_ge   = (rem_q >= {1'b0, den_q});
	assign div_diff = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {1'b0, tq_q - t0_q};
			den_q <= t1_q - t0_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {div_diff[TimeW-1:0], 1'b0};
			quo_q <= {quo_q[FracW-2:0], div_ge};
		end
	end

	// Cubic coefficients.
	assign e0 = SW'(p0_q);
	assign e1 = SW'(p1_q);
	assign e2 = SW'(p2_q);
	assign e3 = SW'(p3_q);
	assign coef_a = e1 <<< 1;
	assign coef_b = e2 - e0;
	assign coef_c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign coef_d = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;

	// Nibble-serial multiply by the fraction, most significant nibble first.
	assign mop     = (cmd.sum_sel == SUM_CD) ? coef_d : s_q;
	assign f20     = {3'b000, quo_q};
	assign nib_sh  = 5'd16 - {cmd.mul_nib, 2'b00};
	assign nib_val = 4'(f20 >> nib_sh);
	assign term    = mop * $signed({1'b0, nib_val});

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (cmd.mul_first) begin
				acc_q <= AccW'(term);
			end else begin
				acc_q <= (acc_q <<< 4) + AccW'(term);
			end
		end
	end

	// Horner accumulation; the B and A steps round the product half-up.
	assign acc_rnd = (acc_q + (AccW'(1) <<< 15)) >>> 16;
	assign s_rnd   = SW'(acc_rnd);

	always_ff @(posedge clk) begin
		if (cmd.s_load) begin
			unique case (cmd.sum_sel)
				SUM_CD:  s_q <= (coef_c <<< 16) + SW'(acc_q);
				SUM_B:   s_q <= (coef_b <<< 16) + s_rnd;
				SUM_A:   s_q <= (coef_a <<< 16) + s_rnd;
				default: s_q <= s_q;
			endcase
		end
	end

	// Final rounding and saturation.
	assign amp_wide = (s_q + (SW'(1) <<< 16)) >>> 17;
	always_comb begin
		if (amp_wide > SW'(32767)) begin
			amp_sat = 16'sh7FFF;
		end else if (amp_wide < -SW'(32768)) begin
			amp_sat = 16'sh8000;
		end else begin
			amp_sat = LevW'(amp_wide);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				RES_ONE:   res_q <= 16'sd16384;
				RES_RD:    res_q <= rd_level;
				RES_P1:    res_q <= p1_q;
				RES_P2:    res_q <= p2_q;
				RES_CUBIC: res_q <= amp_sat;
				default:   res_q <= res_q;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			amplitude     <= cmd.out_query ? res_q : '0;
			table_full    <= cmd.do_insert && full;
			stored_points <= PtsW'(count_next);
		end
	end

endmodule
`default_nettype wire

>>> sv/cre_ctrl.sv
`default_nettype none
module cre_ctrl
	import cre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_mode,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire status_t    status,
	output cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_P1,
		ST_P0,
		ST_P3,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	sum_sel_t   phase_q, phase_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.idx_op  = IDX_HOLD;
		cmd.res_sel = RES_ONE;
		cmd.sum_sel = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode_t'(in_mode) == MODE_QUERY) begin
						cmd.load_query = 1'b1;
						cmd.idx_op     = IDX_ZERO;
						state_d        = ST_FIRST;
					end else begin
						cmd.do_insert = (mode_t'(in_mode) == MODE_INSERT);
						cmd.do_clear  = (mode_t'(in_mode) == MODE_CLEAR);
						cmd.out_load  = 1'b1;
					end
				end
			end
			ST_FIRST: begin
				if (status.n_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ONE;
					state_d      = ST_DONE;
				end else if (status.n_one || status.tq_le_rd) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RD;
					state_d      = ST_DONE;
				end else begin
					cmd.idx_op = IDX_LAST;
					state_d    = ST_LAST;
				end
			end
			ST_LAST: begin
				if (status.tq_ge_rd) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RD;
					state_d      = ST_DONE;
				end else begin
					cmd.idx_op = IDX_ONE;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// The first point at or after the query time closes the segment.
				if (status.tq_le_rd) begin
					cmd.cap_hi = 1'b1;
					cmd.idx_op = IDX_DEC;
					state_d    = ST_P1;
				end else begin
					cmd.idx_op = IDX_INC;
				end
			end
			ST_P1: begin
				cmd.cap_lo = 1'b1;
				if (status.rd_t_eq_t1) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_P2;
					state_d      = ST_DONE;
				end else if (status.rd_l_eq_p2) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RD;
					state_d      = ST_DONE;
				end else if (status.idx_zero) begin
					cmd.p0_dup = 1'b1;
					cmd.idx_op = IDX_ADD2;
					state_d    = ST_P3;
				end else begin
					cmd.idx_op = IDX_DEC;
					state_d    = ST_P0;
				end
			end
			ST_P0: begin
				cmd.cap_p0 = 1'b1;
				if (status.rd_t_eq_t0) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_P1;
					state_d      = ST_DONE;
				end else begin
					cmd.idx_op = IDX_ADD3;
					state_d    = ST_P3;
				end
			end
			ST_P3: begin
				cmd.cap_p3   = 1'b1;
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DivSteps - 1)) begin
					cnt_d   = '0;
					phase_d = SUM_CD;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step  = 1'b1;
				cmd.mul_first = (cnt_q == '0);
				cmd.mul_nib   = cnt_q[2:0];
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == 5'(MulSteps - 1)) begin
					cnt_d   = '0;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.s_load = 1'b1;
				unique case (phase_q)
					SUM_CD: begin
						phase_d = SUM_B;
						state_d = ST_MUL;
					end
					SUM_B: begin
						phase_d = SUM_A;
						state_d = ST_MUL;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_CUBIC;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_query = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, counters and the result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			phase_q     <= SUM_CD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/catmull_rom_breakpoint_envelope.sv
// Insert, clear and no-op transactions: result registered in the cycle after acceptance.
// Query transactions: the segment scan walks the table one entry per cycle through a
// single read port, then inside a segment a divider and three nibble-serial multiplies
// evaluate the cubic. One transaction is in flight at a time,
// and a result held by the receiver also holds off the next input transaction.
// Asynchronous active-low reset empties the table and clears control state.
`default_nettype none
module catmull_rom_breakpoint_envelope
	import cre_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	cre_item_if.sink      item,
	cre_result_if.source  result
);

	cmd_t    cmd;
	status_t status;

	cre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_mode   (item.mode),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cre_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_time       (item.time_pos),
		.in_level      (item.level),
		.amplitude     (result.amplitude),
		.table_full    (result.table_full),
		.stored_points (result.stored_points)
	);

endmodule
`default_nettype wire
